FILE: hdl/sbus_frame_sync_decoder_core_defines.svh
// Assertion macros used by the frame decoder back end.
`ifndef SBUS_FRAME_SYNC_DECODER_CORE_DEFINES_SVH
`define SBUS_FRAME_SYNC_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, idle during reset.
`define SFSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, idle during reset.
`define SFSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFSD_ASSERT_IMP(label, ante, cons, msg)
`define SFSD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/sfsd_pkg.sv
// Shared types and constants of the frame sync decoder.
`default_nettype none

package sfsd_pkg;

    // Stream port widths
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 120;

    // Frame layout
    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_A    = 8'h00;
    localparam logic [7:0] FOOTER_B    = 8'h04;
    localparam int unsigned FRAME_BYTES = 25;
    localparam int unsigned STORE_BYTES = FRAME_BYTES - 2;
    localparam int unsigned DATA_BYTES  = 22;
    localparam int unsigned DATA_W      = DATA_BYTES * 8;
    localparam int unsigned STORE_W     = STORE_BYTES * 8;
    localparam logic [4:0] POS_HUNT     = 5'd0;
    localparam logic [4:0] POS_FOOTER   = 5'(FRAME_BYTES - 1);

    // Channel scaling: raw*1000/1600 + offset, and 1000/1600 is exactly 5/8
    localparam int unsigned RAW_W     = 11;
    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned RAW_MIN   = 200;
    localparam int unsigned RAW_MAX   = 1800;
    localparam int unsigned OUT_MIN   = 1000;
    localparam int unsigned OUT_MAX   = 2000;
    localparam int unsigned SCALE_MUL = OUT_MAX - OUT_MIN;
    localparam int unsigned SCALE_DIV = RAW_MAX - RAW_MIN;
    localparam int unsigned SCALE_OFS = OUT_MIN - (SCALE_MUL * RAW_MIN) / SCALE_DIV;
    localparam int unsigned SCALE_SHIFT = 3;
    localparam int unsigned FAILSAFE_CHANNELS = 4;

    // Frame gap check; gap/20 is (gap>>2)/5 via a reciprocal multiply
    localparam logic [31:0] GAP_LIMIT   = 32'd30;
    localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam int unsigned PROD_W      = 62;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One finished frame handed from front to back
    typedef struct packed {
        logic              bad;
        logic [31:0]       now_ms;
        logic [DATA_W-1:0] data;
    } sfsd_job_t;

    // One result item
    typedef struct packed {
        logic               status;
        logic               last;
        logic [3:0]         channel_index;
        logic [VALUE_W-1:0] channel_value;
        logic               failsafe;
        logic [31:0]        valid_frames;
        logic [31:0]        invalid_frames;
        logic [31:0]        missed_frames;
    } sfsd_result_t;

endpackage

`default_nettype wire

FILE: hdl/sbus_frame_sync_decoder_core.sv
// Top level of the 25-byte, 16-channel serial frame sync decoder.
// Throughput: one input byte per cycle unless the footer byte stalls on a full queue;
// a valid frame gives NUM_CHANNELS results, one per cycle when m_tready stays high, a bad footer gives one result.
// With the back end idle, the first result of a valid frame passes the queue, statistics,
// reciprocal divide and accumulate steps; a bad footer result skips divide and accumulate.
// Reset (rst_n low, asynchronous): header hunt, empty queue, counters, failsafe and last
// frame time cleared; captured frame bytes are not reset.
`default_nettype none

module sbus_frame_sync_decoder_core
    import sfsd_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // byte_value[7:0], now_ms[39:8]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // channel_index[3:0], channel_value[15:4],
                                               // failsafe[16], valid_frames[48:17],
                                               // invalid_frames[80:49], missed_frames[112:81]
    output logic                     m_tuser,  // status
    output logic                     m_tlast
);

    localparam int unsigned PAD_W = M_DATA_W - (4 + VALUE_W + 1 + 96);

    logic         push;
    sfsd_job_t    push_job;
    logic         q_full;
    logic         q_valid;
    sfsd_job_t    q_head;
    logic         q_pop;
    sfsd_result_t result;

    sfsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .byte_value (s_tdata[7:0]),
        .now_ms     (s_tdata[39:8]),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    sfsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    sfsd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // Pack the result request
    assign m_tdata = {PAD_W'(0), result.missed_frames, result.invalid_frames,
                      result.valid_frames, result.failsafe, result.channel_value,
                      result.channel_index};
    assign m_tuser = result.status;
    assign m_tlast = result.last;

endmodule

`default_nettype wire

FILE: hdl/sfsd_front.sv
// Front end: header hunt, frame byte capture and footer check.
`default_nettype none

module sfsd_front
    import sfsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] byte_value,
    input  wire logic [31:0] now_ms,
    input  wire logic       q_full,
    output logic            push,
    output sfsd_job_t       push_job
);

    logic [4:0]         pos_reg;
    logic [4:0]         pos_next;
    logic [STORE_W-1:0] shift_reg;
    logic               accept;
    logic               in_frame;

    // Stall only on the footer byte when the queue has no room
    assign s_tready = (pos_reg != POS_FOOTER) || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_frame = (pos_reg != POS_HUNT) && (pos_reg <= POS_FOOTER);

    // Advance frame position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (!in_frame)
                pos_next = (byte_value == HEADER_BYTE) ? 5'd1 : POS_HUNT;
            else if (pos_reg == POS_FOOTER)
                pos_next = POS_HUNT;
            else
                pos_next = pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_HUNT;
        else
            pos_reg <= pos_next;
    end

    // Shift in frame bytes; byte 1 ends up in the lowest bits
    always_ff @(posedge clk)
    begin
        if (accept && in_frame && (pos_reg != POS_FOOTER))
            shift_reg <= {byte_value, shift_reg[STORE_W-1:8]};
    end

    // Hand the finished frame to the back end on the footer
    assign push            = accept && (pos_reg == POS_FOOTER);
    assign push_job.bad    = (byte_value != FOOTER_A) && (byte_value != FOOTER_B);
    assign push_job.now_ms = now_ms;
    assign push_job.data   = shift_reg[DATA_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/sfsd_queue.sv
// Short frame queue between front and back end.
`default_nettype none

module sfsd_queue
    import sfsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire sfsd_job_t push_job,
    output logic           full,
    output logic           valid,
    output sfsd_job_t      head,
    input  wire logic      pop
);

    sfsd_job_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: hdl/sfsd_back.sv
// Back end: frame statistics, channel unpack and scaling, result output.
`default_nettype none

`include "sbus_frame_sync_decoder_core_defines.svh"

module sfsd_back
    import sfsd_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire sfsd_job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output sfsd_result_t   result
);

    localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg,       state_next;
    logic              err_reg,         err_next;
    logic [3:0]        ch_reg,          ch_next;
    logic [31:0]       prev_time_reg,   prev_time_next;
    logic              gap_hit_reg,     gap_hit_next;
    logic [31:0]       valid_cnt_reg,   valid_cnt_next;
    logic [31:0]       invalid_cnt_reg, invalid_cnt_next;
    logic [31:0]       lost_cnt_reg,    lost_cnt_next;
    logic              failsafe_reg,    failsafe_next;
    logic              out_valid_reg,   out_valid_next;
    logic [DATA_W-1:0] data_reg,        data_next;
    logic [31:0]       gap_reg,         gap_next;
    logic [QUOT_W-1:0] quot_reg,        quot_next;
    sfsd_result_t      out_reg,         out_next;

    logic              out_free;
    logic [31:0]       gap;
    logic              fs_hit;
    logic [7:0]        ch_off;
    logic [RAW_W-1:0]  raw;
    logic [RAW_W+2:0]  raw5;
    logic [VALUE_W-1:0] scaled;
    logic [PROD_W-1:0] prod;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign gap      = q_job.now_ms - prev_time_reg;

    // Failsafe when any of the first channels has raw 0 or 1 (scales to the offset)
    always_comb
    begin
        fs_hit = 1'b0;
        for (int i = 0; i < FAILSAFE_CHANNELS; i++)
        begin
            if (q_job.data[i*RAW_W+1 +: RAW_W-1] == '0)
                fs_hit = 1'b1;
        end
    end

    // Unpack the current channel and scale by 5/8 plus offset
    assign ch_off = 8'(ch_reg) * 8'(RAW_W);
    assign raw    = data_reg[ch_off +: RAW_W];
    assign raw5   = {1'b0, raw, 2'b00} + {3'b000, raw};
    assign scaled = {1'b0, raw5[RAW_W+2:SCALE_SHIFT]} + VALUE_W'(SCALE_OFS);

    // Quotient of gap/20 as (gap/4)*recip(5)
    assign prod = {32'b0, gap_reg[31:2]} * {30'b0, RECIP_5};

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        err_next         = err_reg;
        ch_next          = ch_reg;
        prev_time_next   = prev_time_reg;
        gap_hit_next     = gap_hit_reg;
        valid_cnt_next   = valid_cnt_reg;
        invalid_cnt_next = invalid_cnt_reg;
        lost_cnt_next    = lost_cnt_reg;
        failsafe_next    = failsafe_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        data_next        = data_reg;
        gap_next         = gap_reg;
        quot_next        = quot_reg;
        out_next         = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    data_next = q_job.data;
                    ch_next   = '0;
                    err_next  = q_job.bad;
                    if (q_job.bad)
                    begin
                        invalid_cnt_next = invalid_cnt_reg + 32'd1;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        valid_cnt_next = valid_cnt_reg + 32'd1;
                        failsafe_next  = failsafe_reg || fs_hit;
                        gap_next       = gap;
                        gap_hit_next   = (prev_time_reg != '0) && (gap > GAP_LIMIT);
                        prev_time_next = q_job.now_ms;
                        state_next     = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                quot_next  = prod[PROD_W-1:RECIP_SHIFT];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (gap_hit_reg)
                    lost_cnt_next = lost_cnt_reg + 32'(quot_reg) - 32'd1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = err_reg;
                    out_next.failsafe      = failsafe_reg;
                    out_next.valid_frames  = valid_cnt_reg;
                    out_next.invalid_frames = invalid_cnt_reg;
                    out_next.missed_frames = lost_cnt_reg;
                    if (err_reg)
                    begin
                        out_next.channel_index = '0;
                        out_next.channel_value = '0;
                        out_next.last          = 1'b1;
                        state_next             = ST_IDLE;
                    end
                    else
                    begin
                        out_next.channel_index = ch_reg;
                        out_next.channel_value = scaled;
                        out_next.last          = (ch_reg == LAST_CH);
                        ch_next                = ch_reg + 4'd1;
                        if (ch_reg == LAST_CH)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            err_reg         <= 1'b0;
            ch_reg          <= '0;
            prev_time_reg   <= '0;
            gap_hit_reg     <= 1'b0;
            valid_cnt_reg   <= '0;
            invalid_cnt_reg <= '0;
            lost_cnt_reg    <= '0;
            failsafe_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            err_reg         <= err_next;
            ch_reg          <= ch_next;
            prev_time_reg   <= prev_time_next;
            gap_hit_reg     <= gap_hit_next;
            valid_cnt_reg   <= valid_cnt_next;
            invalid_cnt_reg <= invalid_cnt_next;
            lost_cnt_reg    <= lost_cnt_next;
            failsafe_reg    <= failsafe_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        gap_reg  <= gap_next;
        quot_reg <= quot_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    `SFSD_ASSERT_IMP(a_last_on_final_channel, out_valid_reg && !out_reg.status && out_reg.last, out_reg.channel_index == LAST_CH, "last flag on wrong channel")
    `SFSD_ASSERT_IMP(a_error_result_shape, out_valid_reg && out_reg.status, out_reg.last && (out_reg.channel_index == '0) && (out_reg.channel_value == '0), "malformed error result")
    `SFSD_ASSERT_NXT(a_idle_holds, (state_reg == ST_IDLE) && !q_valid, state_reg == ST_IDLE, "left idle without a frame")
    `SFSD_ASSERT_NXT(a_valid_frame_calc, (state_reg == ST_IDLE) && q_valid && !q_job.bad, (state_reg == ST_CALC) && (valid_cnt_reg == $past(valid_cnt_reg) + 32'd1), "valid frame not taken")

endmodule

`default_nettype wire
